FILE: sv/bsfd_pkg.sv
package bsfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned POS_W = 11;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam logic [POS_W-1:0] MAX_BUFFER = POS_W'(1024);

	localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_CODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TAIL_CODE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_CODE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPED_HEAD_CODE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPED_TAIL_CODE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPED_ESCAPE_CODE = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_SIZE = 3'd6;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_FRAME = 2'd1,
		PH_ESC = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] head_code;
		logic [BYTE_W-1:0] tail_code;
		logic [BYTE_W-1:0] escape_code;
		logic [BYTE_W-1:0] escaped_head_code;
		logic [BYTE_W-1:0] escaped_tail_code;
		logic [BYTE_W-1:0] escaped_escape_code;
		logic [POS_W-1:0] buffer_size;
	} cfg_t;

	typedef struct packed {
		logic write_valid;
		logic [IDX_W-1:0] write_index;
		logic [BYTE_W-1:0] decoded_byte;
		logic frame_end;
		logic frame_abort;
	} result_t;

endpackage

FILE: sv/bsfd_cfg_regs.sv
module bsfd_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [bsfd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [bsfd_pkg::CFG_DATA_W-1:0] cfg_data,
	output bsfd_pkg::cfg_t cfg
);

	bsfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_code <= 8'd126;
			cfg_q.tail_code <= 8'd127;
			cfg_q.escape_code <= 8'd125;
			cfg_q.escaped_head_code <= 8'd2;
			cfg_q.escaped_tail_code <= 8'd3;
			cfg_q.escaped_escape_code <= 8'd1;
			cfg_q.buffer_size <= 11'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsfd_pkg::CFG_HEAD_CODE: cfg_q.head_code <= cfg_data[7:0];
				bsfd_pkg::CFG_TAIL_CODE: cfg_q.tail_code <= cfg_data[7:0];
				bsfd_pkg::CFG_ESCAPE_CODE: cfg_q.escape_code <= cfg_data[7:0];
				bsfd_pkg::CFG_ESCAPED_HEAD_CODE: cfg_q.escaped_head_code <= cfg_data[7:0];
				bsfd_pkg::CFG_ESCAPED_TAIL_CODE: cfg_q.escaped_tail_code <= cfg_data[7:0];
				bsfd_pkg::CFG_ESCAPED_ESCAPE_CODE: cfg_q.escaped_escape_code <= cfg_data[7:0];
				bsfd_pkg::CFG_BUFFER_SIZE: cfg_q.buffer_size <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/bsfd_step.sv
module bsfd_step (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [bsfd_pkg::BYTE_W-1:0] byte_in,
	input bsfd_pkg::cfg_t cfg,
	output bsfd_pkg::result_t result
);

	bsfd_pkg::phase_t phase_q, phase_mid, phase_d;
	logic [bsfd_pkg::POS_W-1:0] pos_q, pos_mid, pos_d, size_eff, pos_inc;
	logic [bsfd_pkg::BYTE_W-1:0] wbyte, mapped;
	logic is_head, is_tail, is_esc, map_ok, wr, done, esc_bad, check, full;

	assign is_head = (byte_in == cfg.head_code);
	assign is_tail = (byte_in == cfg.tail_code);
	assign is_esc = (byte_in == cfg.escape_code);
	assign size_eff = (cfg.buffer_size > bsfd_pkg::MAX_BUFFER) ?
		bsfd_pkg::MAX_BUFFER : cfg.buffer_size;
	assign pos_inc = pos_q + bsfd_pkg::POS_W'(1);

	always_comb begin
		map_ok = 1'b1;
		priority if (byte_in == cfg.escaped_head_code) begin
			mapped = cfg.head_code;
		end else if (byte_in == cfg.escaped_tail_code) begin
			mapped = cfg.tail_code;
		end else if (byte_in == cfg.escaped_escape_code) begin
			mapped = cfg.escape_code;
		end else begin
			mapped = '0;
			map_ok = 1'b0;
		end
	end

	always_comb begin
		wr = 1'b0;
		wbyte = byte_in;
		done = 1'b0;
		esc_bad = 1'b0;
		check = 1'b1;
		pos_mid = pos_q;
		if (is_head) begin
			wr = 1'b1;
			pos_mid = bsfd_pkg::POS_W'(1);
		end else begin
			unique case (phase_q)
				bsfd_pkg::PH_FRAME: begin
					if (!is_esc) begin
						wr = 1'b1;
						pos_mid = pos_inc;
						if (is_tail) begin
							done = 1'b1;
							check = 1'b0;
						end
					end
				end
				bsfd_pkg::PH_ESC: begin
					if (map_ok) begin
						wr = 1'b1;
						wbyte = mapped;
						pos_mid = pos_inc;
					end else begin
						esc_bad = 1'b1;
						check = 1'b0;
						pos_mid = '0;
					end
				end
				default: ;
			endcase
		end
	end

	assign full = check && (pos_mid >= size_eff);

	always_comb begin
		phase_mid = phase_q;
		if (is_head) begin
			phase_mid = bsfd_pkg::PH_FRAME;
		end else begin
			unique case (phase_q)
				bsfd_pkg::PH_FRAME: begin
					if (is_esc) begin
						phase_mid = bsfd_pkg::PH_ESC;
					end else if (is_tail) begin
						phase_mid = bsfd_pkg::PH_DONE;
					end
				end
				bsfd_pkg::PH_ESC: phase_mid = map_ok ? bsfd_pkg::PH_FRAME : bsfd_pkg::PH_IDLE;
				default: ;
			endcase
		end
		phase_d = full ? bsfd_pkg::PH_IDLE : phase_mid;
	end

	always_comb begin
		pos_d = full ? '0 : pos_mid;
		result.write_valid = wr;
		result.write_index = wr ? (is_head ? '0 : pos_q[bsfd_pkg::IDX_W-1:0]) : '0;
		result.decoded_byte = wr ? wbyte : '0;
		result.frame_end = done;
		result.frame_abort = esc_bad ||
			(full && (phase_mid == bsfd_pkg::PH_FRAME || phase_mid == bsfd_pkg::PH_ESC));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bsfd_pkg::PH_IDLE;
			pos_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
		end
	end

endmodule

FILE: sv/byte_stuffing_frame_decoder_unit.sv
// Byte-stuffing frame decoder, receive side.
// Input channel: in_valid/in_ready with line_byte, one raw line byte per
// transaction. Output channel: out_valid/out_ready with write_valid,
// write_index, decoded_byte, frame_end and frame_abort; exactly one result
// transaction per input transaction, in order.
// Configuration: cfg_we/cfg_index/cfg_data write the code bytes and the
// buffer size, one register per write; write only while no transaction is in flight.
// Flow: a byte taken into the input register is decoded into the result register
// when it advances, and its result transaction completes from the result register.
// Throughput: one byte per cycle while the receiver accepts results, set by the
// single decode step between the two registers; the frame state advances as
// each byte moves into the result register.
// Reset clears the frame state to idle at position zero, empties both
// registers and loads the default codes and a 256-byte buffer size.
// When the receiver stalls the result register holds, the input register
// keeps one more byte, and in_ready falls only when both are occupied.
module byte_stuffing_frame_decoder_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [bsfd_pkg::BYTE_W-1:0] line_byte,
	output logic out_valid,
	input logic out_ready,
	output logic write_valid,
	output logic [bsfd_pkg::IDX_W-1:0] write_index,
	output logic [bsfd_pkg::BYTE_W-1:0] decoded_byte,
	output logic frame_end,
	output logic frame_abort,
	input logic cfg_we,
	input logic [bsfd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [bsfd_pkg::CFG_DATA_W-1:0] cfg_data
);

	bsfd_pkg::cfg_t cfg;
	bsfd_pkg::result_t result, result_s2;
	logic [bsfd_pkg::BYTE_W-1:0] byte_s1;
	logic valid_s1, valid_s2, advance;

	bsfd_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	bsfd_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.byte_in(byte_s1),
		.cfg(cfg),
		.result(result)
	);

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= line_byte;
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign write_valid = result_s2.write_valid;
	assign write_index = result_s2.write_index;
	assign decoded_byte = result_s2.decoded_byte;
	assign frame_end = result_s2.frame_end;
	assign frame_abort = result_s2.frame_abort;

endmodule

FILE: tb/tb_byte_stuffing_frame_decoder_unit.sv
module tb_byte_stuffing_frame_decoder_unit;
	import bsfd_pkg::*;

	typedef logic [CFG_DATA_W-1:0] reg_vals_t [7];

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 330;
	localparam logic [CFG_INDEX_W-1:0] REG_INDEX [7] = '{CFG_HEAD_CODE, CFG_TAIL_CODE,
		CFG_ESCAPE_CODE, CFG_ESCAPED_HEAD_CODE, CFG_ESCAPED_TAIL_CODE,
		CFG_ESCAPED_ESCAPE_CODE, CFG_BUFFER_SIZE};
	localparam reg_vals_t DEFAULT_REGS = '{11'd126, 11'd127, 11'd125, 11'd2, 11'd3, 11'd1,
		11'd256};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [BYTE_W-1:0] line_byte;
	logic out_valid;
	logic out_ready;
	logic write_valid;
	logic [IDX_W-1:0] write_index;
	logic [BYTE_W-1:0] decoded_byte;
	logic frame_end;
	logic frame_abort;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfg_t cur_cfg;
	phase_t fr_phase;
	logic [POS_W-1:0] fr_pos;
	result_t expected_results [$];

	bit no_idle = 1'b0;
	int sent_count = 0;
	int results_seen = 0;
	int frames_closed = 0;
	int frames_dropped = 0;
	int settings_count = 0;
	int mismatches = 0;
	int cycle_count = 0;

	byte_stuffing_frame_decoder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.line_byte(line_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.write_valid(write_valid),
		.write_index(write_index),
		.decoded_byte(decoded_byte),
		.frame_end(frame_end),
		.frame_abort(frame_abort),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void load_config(input reg_vals_t v);
		cur_cfg.head_code = v[CFG_HEAD_CODE][BYTE_W-1:0];
		cur_cfg.tail_code = v[CFG_TAIL_CODE][BYTE_W-1:0];
		cur_cfg.escape_code = v[CFG_ESCAPE_CODE][BYTE_W-1:0];
		cur_cfg.escaped_head_code = v[CFG_ESCAPED_HEAD_CODE][BYTE_W-1:0];
		cur_cfg.escaped_tail_code = v[CFG_ESCAPED_TAIL_CODE][BYTE_W-1:0];
		cur_cfg.escaped_escape_code = v[CFG_ESCAPED_ESCAPE_CODE][BYTE_W-1:0];
		cur_cfg.buffer_size = v[CFG_BUFFER_SIZE];
	endfunction

	function automatic result_t decode_step(input logic [BYTE_W-1:0] b);
		result_t r;
		logic [POS_W-1:0] lim;
		logic [POS_W-1:0] pos;
		logic [BYTE_W-1:0] mapped;
		logic full_check;
		logic code_ok;
		r = '0;
		full_check = 1'b1;
		code_ok = 1'b1;
		mapped = '0;
		lim = (cur_cfg.buffer_size > MAX_BUFFER) ? MAX_BUFFER : cur_cfg.buffer_size;
		pos = fr_pos;
		if (b == cur_cfg.head_code) begin
			fr_phase = PH_FRAME;
			r.write_valid = 1'b1;
			r.write_index = '0;
			r.decoded_byte = b;
			pos = POS_W'(1);
		end else if (fr_phase == PH_FRAME) begin
			if (b == cur_cfg.escape_code) begin
				fr_phase = PH_ESC;
			end else if (b == cur_cfg.tail_code) begin
				r.write_valid = 1'b1;
				r.write_index = pos[IDX_W-1:0];
				r.decoded_byte = b;
				pos = pos + POS_W'(1);
				fr_phase = PH_DONE;
				r.frame_end = 1'b1;
				full_check = 1'b0;
			end else begin
				r.write_valid = 1'b1;
				r.write_index = pos[IDX_W-1:0];
				r.decoded_byte = b;
				pos = pos + POS_W'(1);
			end
		end else if (fr_phase == PH_ESC) begin
			if (b == cur_cfg.escaped_head_code) mapped = cur_cfg.head_code;
			else if (b == cur_cfg.escaped_tail_code) mapped = cur_cfg.tail_code;
			else if (b == cur_cfg.escaped_escape_code) mapped = cur_cfg.escape_code;
			else code_ok = 1'b0;
			if (code_ok) begin
				r.write_valid = 1'b1;
				r.write_index = pos[IDX_W-1:0];
				r.decoded_byte = mapped;
				pos = pos + POS_W'(1);
				fr_phase = PH_FRAME;
			end else begin
				fr_phase = PH_IDLE;
				pos = '0;
				r.frame_abort = 1'b1;
				full_check = 1'b0;
			end
		end
		if (full_check && pos >= lim) begin
			if (fr_phase == PH_FRAME || fr_phase == PH_ESC) r.frame_abort = 1'b1;
			fr_phase = PH_IDLE;
			pos = '0;
		end
		fr_pos = pos;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		in_valid <= 1'b1;
		line_byte <= b;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(decode_step(b));
		sent_count++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// hold the sender until every transaction in flight has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_config(input reg_vals_t v);
		drain();
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_INDEX[i];
			cfg_data <= v[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		load_config(v);
		settings_count++;
	endtask

	task automatic send_frame(input int plen, input int ending);
		logic [BYTE_W-1:0] b;
		send_byte(cur_cfg.head_code);
		for (int i = 0; i < plen; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 2))
					0: b = cur_cfg.head_code;
					1: b = cur_cfg.tail_code;
					default: b = cur_cfg.escape_code;
				endcase
			end else begin
				b = BYTE_W'($urandom);
			end
			if (b == cur_cfg.head_code) begin
				send_byte(cur_cfg.escape_code);
				send_byte(cur_cfg.escaped_head_code);
			end else if (b == cur_cfg.tail_code) begin
				send_byte(cur_cfg.escape_code);
				send_byte(cur_cfg.escaped_tail_code);
			end else if (b == cur_cfg.escape_code) begin
				send_byte(cur_cfg.escape_code);
				send_byte(cur_cfg.escaped_escape_code);
			end else begin
				send_byte(b);
			end
		end
		case (ending)
			0: send_byte(cur_cfg.tail_code);
			1: begin
				send_byte(cur_cfg.escape_code);
				send_byte(BYTE_W'($urandom));
			end
			default: ;
		endcase
	endtask

	task automatic test_stuffing_basics();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(cur_cfg.head_code);
		send_byte(8'h41);
		send_byte(cur_cfg.escape_code);
		send_byte(cur_cfg.escaped_head_code);
		send_byte(cur_cfg.escape_code);
		send_byte(cur_cfg.escaped_tail_code);
		send_byte(cur_cfg.escape_code);
		send_byte(cur_cfg.escaped_escape_code);
		// head during escape restarts the frame
		send_byte(cur_cfg.escape_code);
		send_byte(cur_cfg.head_code);
		send_byte(cur_cfg.tail_code);
		send_byte(8'h55);
		send_byte(cur_cfg.head_code);
		send_byte(cur_cfg.escape_code);
		send_byte(8'h09);
		send_byte(cur_cfg.tail_code);
	endtask

	task automatic test_buffer_full();
		reg_vals_t v;
		v = DEFAULT_REGS;
		v[CFG_BUFFER_SIZE] = 11'd2;
		set_config(v);
		send_byte(cur_cfg.head_code);
		send_byte(8'h41);
		send_byte(cur_cfg.head_code);
		send_byte(cur_cfg.tail_code);
		send_byte(8'h11);
		v[CFG_BUFFER_SIZE] = 11'd0;
		set_config(v);
		send_byte(cur_cfg.head_code);
	endtask

	task automatic test_code_collisions();
		reg_vals_t v;
		v = DEFAULT_REGS;
		v[CFG_TAIL_CODE] = 11'h020;
		v[CFG_ESCAPE_CODE] = 11'h020;
		v[CFG_ESCAPED_HEAD_CODE] = 11'h005;
		v[CFG_ESCAPED_TAIL_CODE] = 11'h005;
		v[CFG_ESCAPED_ESCAPE_CODE] = 11'h005;
		set_config(v);
		send_byte(cur_cfg.head_code);
		send_byte(8'h20);
		send_byte(8'h05);
		send_byte(8'h20);
		send_byte(8'h20);
		v = DEFAULT_REGS;
		v[CFG_HEAD_CODE] = 11'h040;
		v[CFG_ESCAPE_CODE] = 11'h040;
		set_config(v);
		send_byte(8'h40);
		send_byte(8'h40);
	endtask

	// size above the cap: the last payload byte lands at index 1023 and fills the buffer
	task automatic test_long_frame();
		reg_vals_t v;
		logic [BYTE_W-1:0] b;
		v = DEFAULT_REGS;
		v[CFG_BUFFER_SIZE] = 11'd2047;
		set_config(v);
		send_byte(cur_cfg.head_code);
		repeat (1023) begin
			do b = BYTE_W'($urandom);
			while (b == cur_cfg.head_code || b == cur_cfg.tail_code ||
				b == cur_cfg.escape_code);
			send_byte(b);
		end
		send_byte(8'h33);
	endtask

	function automatic reg_vals_t random_settings();
		reg_vals_t v;
		logic [BYTE_W-1:0] a;
		v = DEFAULT_REGS;
		a = BYTE_W'($urandom);
		case ($urandom_range(0, 3))
			0: ;
			1: for (int i = 0; i < 6; i++) v[i] = CFG_DATA_W'($urandom_range(0, 255));
			2: begin
				if ($urandom_range(0, 1)) begin
					v[CFG_HEAD_CODE] = 11'd0;
					v[CFG_TAIL_CODE] = 11'd255;
					v[CFG_ESCAPE_CODE] = 11'd128;
					v[CFG_ESCAPED_HEAD_CODE] = 11'd255;
					v[CFG_ESCAPED_TAIL_CODE] = 11'd0;
					v[CFG_ESCAPED_ESCAPE_CODE] = 11'd127;
				end else begin
					v[CFG_HEAD_CODE] = 11'd255;
					v[CFG_TAIL_CODE] = 11'd0;
					v[CFG_ESCAPE_CODE] = 11'd1;
					v[CFG_ESCAPED_HEAD_CODE] = 11'd0;
					v[CFG_ESCAPED_TAIL_CODE] = 11'd254;
					v[CFG_ESCAPED_ESCAPE_CODE] = 11'd255;
				end
			end
			default: for (int i = 0; i < 6; i++)
				v[i] = $urandom_range(0, 1) ? {3'b000, a} : 11'($urandom_range(0, 255));
		endcase
		// upper data bits are unused by the byte registers
		for (int i = 0; i < 6; i++) v[i][CFG_DATA_W-1:BYTE_W] = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
				v[CFG_BUFFER_SIZE] = CFG_DATA_W'($urandom_range(1, 8));
			10, 11, 12, 13: v[CFG_BUFFER_SIZE] = CFG_DATA_W'($urandom_range(9, 64));
			14: v[CFG_BUFFER_SIZE] = 11'd0;
			15: v[CFG_BUFFER_SIZE] = 11'd1024;
			16: v[CFG_BUFFER_SIZE] = 11'd2047;
			17: v[CFG_BUFFER_SIZE] = CFG_DATA_W'($urandom_range(1025, 2046));
			18: v[CFG_BUFFER_SIZE] = 11'd256;
			default: v[CFG_BUFFER_SIZE] = CFG_DATA_W'($urandom_range(1, 3));
		endcase
		return v;
	endfunction

	task automatic test_random_traffic();
		reg_vals_t v;
		int stop_at;
		int lim;
		int kind;
		int plen;
		stop_at = sent_count + RANDOM_ITEMS;
		while (sent_count < stop_at) begin
			v = random_settings();
			set_config(v);
			lim = (v[CFG_BUFFER_SIZE] > MAX_BUFFER) ? int'(MAX_BUFFER) : int'(v[CFG_BUFFER_SIZE]);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(3, 10)) begin
				if (sent_count >= stop_at) break;
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom));
				end else begin
					plen = (lim <= 12) ? $urandom_range(0, lim + 1) : $urandom_range(0, 20);
					send_frame(plen, (kind == 1) ? 1 : (kind == 2) ? 2 : 0);
				end
				if ($urandom_range(0, 19) == 0) drain();
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			@(negedge clk);
			gap = pick_gap();
			if (gap == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (write_valid !== want.write_valid) begin
					$error("write_valid: expected %0d, actual %0d", want.write_valid, write_valid);
					mismatches++;
				end
				if (write_index !== want.write_index) begin
					$error("write_index: expected %0d, actual %0d", want.write_index, write_index);
					mismatches++;
				end
				if (decoded_byte !== want.decoded_byte) begin
					$error("decoded_byte: expected 0x%02h, actual 0x%02h", want.decoded_byte,
						decoded_byte);
					mismatches++;
				end
				if (frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, actual %0d", want.frame_end, frame_end);
					mismatches++;
				end
				if (frame_abort !== want.frame_abort) begin
					$error("frame_abort: expected %0d, actual %0d", want.frame_abort, frame_abort);
					mismatches++;
				end
				if (want.frame_end) frames_closed++;
				if (want.frame_abort) frames_dropped++;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		line_byte = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		load_config(DEFAULT_REGS);
		fr_phase = PH_IDLE;
		fr_pos = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_stuffing_basics();
		test_buffer_full();
		test_code_collisions();
		test_long_frame();
		test_random_traffic();
		drain();
		repeat (4) @(posedge clk);
		$display("Covered %0d line bytes under %0d register settings: stuffing, bad escapes,",
			sent_count, settings_count);
		$display("code collisions, full and clamped buffers; %0d results, %0d closed, %0d dropped",
			results_seen, frames_closed, frames_dropped);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
